[hdl/tun_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tun_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int UNIT_SHIFT     = 14;
   localparam int UNIT_W         = 16;
   localparam int PRE_STAGES     = 6;
   localparam int LANE_STAGES    = UNIT_SHIFT + 1;
   // accept edge to result strobe
   localparam int LATENCY        = PRE_STAGES + LANE_STAGES + 1;

   typedef struct packed {
      logic valid;
      logic neg;
      logic degen;
   } tun_ctl_type;

endpackage
`default_nettype wire

[hdl/tun_div_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// Restoring quotient of |n| * 2^14 / sqrt(len2), one bit per stage.
// d holds n^2*2^28 - q^2*len2, t holds q*len2; no multipliers needed.
module tun_div_lane #(
   parameter int LW = 70
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire tun_pkg::tun_ctl_type                ctl_in,
   input  wire logic [LW+2*tun_pkg::UNIT_SHIFT-1:0] num_in,
   input  wire logic [LW-1:0]                       len_in,
   output tun_pkg::tun_ctl_type                     ctl_out,
   output logic [tun_pkg::UNIT_SHIFT:0]             q_out
);
   import tun_pkg::*;

   localparam int DW  = LW + 2 * UNIT_SHIFT;
   localparam int TW  = LW + UNIT_SHIFT + 1;
   localparam int QW  = UNIT_SHIFT + 1;
   localparam int TRW = LW + 2 * UNIT_SHIFT + 2;
   localparam int NST = LANE_STAGES;

   logic [DW-1:0]   d_ff   [0:NST-1];
   logic [TW-1:0]   t_ff   [0:NST-1];
   logic [LW-1:0]   s_ff   [0:NST-1];
   logic [QW-1:0]   q_ff   [0:NST-1];
   tun_ctl_type     ctl_ff [0:NST-1];

   for (genvar k = 0; k < NST; k++) begin : g_stage
      localparam int B = UNIT_SHIFT - k;
      logic [DW-1:0]  d_src;
      logic [TW-1:0]  t_src;
      logic [LW-1:0]  s_src;
      logic [QW-1:0]  q_src;
      tun_ctl_type    ctl_src;
      logic [TRW-1:0] trial;
      logic           take;

      if (k == 0) begin : g_first
         assign d_src   = num_in;
         assign t_src   = '0;
         assign s_src   = len_in;
         assign q_src   = '0;
         assign ctl_src = ctl_in;
      end else begin : g_next
         assign d_src   = d_ff[k-1];
         assign t_src   = t_ff[k-1];
         assign s_src   = s_ff[k-1];
         assign q_src   = q_ff[k-1];
         assign ctl_src = ctl_ff[k-1];
      end

      // (q+2^B)^2*S - q^2*S = 2^(B+1)*T + 2^(2B)*S
      assign trial = (TRW'(t_src) << (B + 1)) + (TRW'(s_src) << (2 * B));
      assign take  = trial <= TRW'(d_src);

      always_ff @(posedge clock) begin
         d_ff[k] <= take ? d_src - DW'(trial) : d_src;
         t_ff[k] <= take ? t_src + (TW'(s_src) << B) : t_src;
         s_ff[k] <= s_src;
         q_ff[k] <= take ? (q_src | (QW'(1) << B)) : q_src;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else begin
            ctl_ff[k] <= ctl_src;
         end
      end
   end

   assign ctl_out = ctl_ff[NST-1];
   assign q_out   = q_ff[NST-1];

endmodule
`default_nettype wire

[hdl/triangle_unit_normal.sv]
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one triangle per cycle; busy is always low.
// Six front stages (edges, products, cross, square partials, squares, length),
// then 15 one-bit quotient stages per component, then the output register.
// Reset (synchronous) clears all valid bits; items in flight are dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
module triangle_unit_normal #(
   parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [COORD_BITS-1:0] req_p1_x,
   input  wire logic signed [COORD_BITS-1:0] req_p1_y,
   input  wire logic signed [COORD_BITS-1:0] req_p1_z,
   input  wire logic signed [COORD_BITS-1:0] req_p2_x,
   input  wire logic signed [COORD_BITS-1:0] req_p2_y,
   input  wire logic signed [COORD_BITS-1:0] req_p2_z,
   input  wire logic signed [COORD_BITS-1:0] req_p3_x,
   input  wire logic signed [COORD_BITS-1:0] req_p3_y,
   input  wire logic signed [COORD_BITS-1:0] req_p3_z,
   output logic                              rsp_valid,
   output logic signed [15:0]                rsp_unit_x,
   output logic signed [15:0]                rsp_unit_y,
   output logic signed [15:0]                rsp_unit_z,
   output logic                              rsp_degenerate
);
   import tun_pkg::*;

   localparam int EW  = COORD_BITS + 1;
   localparam int PW  = 2 * EW;
   localparam int NW  = 2 * COORD_BITS + 2;   // |cross| magnitude bits
   localparam int HL  = NW / 2;
   localparam int HH  = NW - HL;
   localparam int SQW = 2 * NW;
   localparam int LW  = SQW + 2;
   localparam int DW  = LW + 2 * UNIT_SHIFT;
   localparam int QW  = UNIT_SHIFT + 1;

   logic accept;
   logic [PRE_STAGES-1:0] vld_ff;

   // stage 1: edges
   logic signed [EW-1:0] ex_ff, ey_ff, ez_ff, fx_ff, fy_ff, fz_ff;
   // stage 2: products
   logic signed [PW-1:0] pa_ff [0:2];
   logic signed [PW-1:0] pb_ff [0:2];
   // stage 3: cross magnitude and sign
   logic [NW-1:0]        nmag_ff [0:2];
   logic                 neg3_ff [0:2];
   // stage 4: square partials
   logic [2*HH-1:0]      hh_ff [0:2];
   logic [HH+HL-1:0]     hl_ff [0:2];
   logic [2*HL-1:0]      ll_ff [0:2];
   logic                 neg4_ff [0:2];
   // stage 5: squares
   logic [SQW-1:0]       sq_ff [0:2];
   logic                 neg5_ff [0:2];
   // stage 6: length squared and dividends
   logic [LW-1:0]        len_ff;
   logic [DW-1:0]        num_ff [0:2];
   logic                 neg6_ff [0:2];
   logic                 degen6_ff;

   tun_ctl_type          lane_ctl_in  [0:2];
   tun_ctl_type          lane_ctl_out [0:2];
   logic [QW-1:0]        lane_q       [0:2];
   logic signed [UNIT_W-1:0] unit_in  [0:2];

   logic                     rsp_valid_ff;
   logic                     rsp_degen_ff;
   logic signed [UNIT_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PRE_STAGES-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      ex_ff <= EW'(req_p2_x) - EW'(req_p1_x);
      ey_ff <= EW'(req_p2_y) - EW'(req_p1_y);
      ez_ff <= EW'(req_p2_z) - EW'(req_p1_z);
      fx_ff <= EW'(req_p3_x) - EW'(req_p1_x);
      fy_ff <= EW'(req_p3_y) - EW'(req_p1_y);
      fz_ff <= EW'(req_p3_z) - EW'(req_p1_z);

      pa_ff[0] <= ey_ff * fz_ff;
      pb_ff[0] <= ez_ff * fy_ff;
      pa_ff[1] <= ez_ff * fx_ff;
      pb_ff[1] <= ex_ff * fz_ff;
      pa_ff[2] <= ex_ff * fy_ff;
      pb_ff[2] <= ey_ff * fx_ff;
   end

   for (genvar i = 0; i < 3; i++) begin : g_comp
      logic signed [NW:0] diff;
      logic [NW-1:0]      mag;
      assign diff = (NW+1)'(pa_ff[i]) - (NW+1)'(pb_ff[i]);
      assign mag  = diff[NW] ? NW'(-diff) : diff[NW-1:0];

      always_ff @(posedge clock) begin
         nmag_ff[i] <= mag;
         neg3_ff[i] <= diff[NW];

         hh_ff[i]   <= nmag_ff[i][NW-1:HL] * nmag_ff[i][NW-1:HL];
         hl_ff[i]   <= nmag_ff[i][NW-1:HL] * nmag_ff[i][HL-1:0];
         ll_ff[i]   <= nmag_ff[i][HL-1:0] * nmag_ff[i][HL-1:0];
         neg4_ff[i] <= neg3_ff[i];

         sq_ff[i]   <= (SQW'(hh_ff[i]) << (2 * HL)) + (SQW'(hl_ff[i]) << (HL + 1))
                       + SQW'(ll_ff[i]);
         neg5_ff[i] <= neg4_ff[i];

         num_ff[i]  <= DW'(sq_ff[i]) << (2 * UNIT_SHIFT);
         neg6_ff[i] <= neg5_ff[i];
      end

      assign lane_ctl_in[i] = '{valid: vld_ff[PRE_STAGES-1], neg: neg6_ff[i],
                                degen: degen6_ff};

      tun_div_lane #(
         .LW (LW)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl_in  (lane_ctl_in[i]),
         .num_in  (num_ff[i]),
         .len_in  (len_ff),
         .ctl_out (lane_ctl_out[i]),
         .q_out   (lane_q[i])
      );

      // a zero length lets every trial pass, so degenerate forces zero
      always_comb begin
         if (lane_ctl_out[i].degen) begin
            unit_in[i] = '0;
         end else if (lane_ctl_out[i].neg) begin
            unit_in[i] = -$signed(UNIT_W'(lane_q[i]));
         end else begin
            unit_in[i] = $signed(UNIT_W'(lane_q[i]));
         end
      end
   end

   always_ff @(posedge clock) begin
      len_ff    <= LW'(sq_ff[0]) + LW'(sq_ff[1]) + LW'(sq_ff[2]);
      degen6_ff <= (sq_ff[0] == '0) && (sq_ff[1] == '0) && (sq_ff[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= lane_ctl_out[0].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff     <= unit_in[0];
      rsp_y_ff     <= unit_in[1];
      rsp_z_ff     <= unit_in[2];
      rsp_degen_ff <= lane_ctl_out[0].degen;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_unit_x     = rsp_x_ff;
   assign rsp_unit_y     = rsp_y_ff;
   assign rsp_unit_z     = rsp_z_ff;
   assign rsp_degenerate = rsp_degen_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(LATENCY) rsp_valid)
      else $error("transfer did not produce a result at the expected latency");

   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (rsp_unit_x == 0 && rsp_unit_y == 0 && rsp_unit_z == 0))
      else $error("degenerate result with nonzero normal");

   a_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_degenerate) |->
         (rsp_unit_x != 0 || rsp_unit_y != 0 || rsp_unit_z != 0))
      else $error("non-degenerate result with zero normal");

   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_unit_x >= -16384 && rsp_unit_x <= 16384 &&
                     rsp_unit_y >= -16384 && rsp_unit_y <= 16384 &&
                     rsp_unit_z >= -16384 && rsp_unit_z <= 16384))
      else $error("normal component beyond unit magnitude");

endmodule
`default_nettype wire

[tb/sv/triangle_unit_normal_checker.sv]
`timescale 1ns / 1ps
module triangle_unit_normal_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [8:0][15:0]    verts,
   input  logic                rsp_valid,
   input  logic signed [15:0]  rsp_unit_x,
   input  logic signed [15:0]  rsp_unit_y,
   input  logic signed [15:0]  rsp_unit_z,
   input  logic                rsp_degenerate,
   output int                  fail_count,
   output int                  pending
);

   typedef struct packed {
      logic [15:0] ux;
      logic [15:0] uy;
      logic [15:0] uz;
      logic        degen;
   } normal_type;

   normal_type normals_due[$];

   // exact cross product, then largest q with q^2*|N|^2 <= Ni^2*2^28, signed
   function automatic normal_type unit_normal(input logic [8:0][15:0] v);
      logic signed [17:0] ex, ey, ez, fx, fy, fz;
      logic signed [36:0] n [3];
      logic signed [36:0] a;
      logic [127:0] m [3];
      logic [127:0] len2, rhs, cand, lhs;
      logic [15:0] q [3];
      normal_type r;
      ex = $signed(v[3]) - $signed(v[0]);
      ey = $signed(v[4]) - $signed(v[1]);
      ez = $signed(v[5]) - $signed(v[2]);
      fx = $signed(v[6]) - $signed(v[0]);
      fy = $signed(v[7]) - $signed(v[1]);
      fz = $signed(v[8]) - $signed(v[2]);
      n[0] = ey * fz - ez * fy;
      n[1] = ez * fx - ex * fz;
      n[2] = ex * fy - ey * fx;
      for (int i = 0; i < 3; i++) begin
         a = n[i] < 0 ? -n[i] : n[i];
         m[i] = {91'b0, a};
      end
      len2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      r = '0;
      if (len2 == 0) begin
         r.degen = 1'b1;
         return r;
      end
      for (int i = 0; i < 3; i++) begin
         rhs = (m[i] * m[i]) << 28;
         q[i] = '0;
         for (int b = 14; b >= 0; b--) begin
            cand = {112'b0, q[i] | (16'd1 << b)};
            lhs = cand * cand * len2;
            if (lhs <= rhs) q[i] = cand[15:0];
         end
         if (n[i] < 0) q[i] = -q[i];
      end
      r.ux = q[0];
      r.uy = q[1];
      r.uz = q[2];
      return r;
   endfunction

   always @(posedge clock) begin
      normal_type e;
      if (!reset) begin
         if (start && !busy) normals_due.push_back(unit_normal(verts));
         if (rsp_valid) begin
            if (normals_due.size() == 0) begin
               $error("result transfer with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               e = normals_due.pop_front();
               if (rsp_unit_x !== e.ux || rsp_unit_y !== e.uy || rsp_unit_z !== e.uz ||
                   rsp_degenerate !== e.degen) begin
                  if (rsp_unit_x !== e.ux)
                     $error("unit_x: expected %0d, got %0d", $signed(e.ux), rsp_unit_x);
                  if (rsp_unit_y !== e.uy)
                     $error("unit_y: expected %0d, got %0d", $signed(e.uy), rsp_unit_y);
                  if (rsp_unit_z !== e.uz)
                     $error("unit_z: expected %0d, got %0d", $signed(e.uz), rsp_unit_z);
                  if (rsp_degenerate !== e.degen)
                     $error("degenerate: expected %0d, got %0d", e.degen, rsp_degenerate);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= normals_due.size();
   end

endmodule

[tb/sv/triangle_unit_normal_tb.sv]
`timescale 1ns / 1ps
module triangle_unit_normal_tb;
   import tun_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int N_RANDOM = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [8:0][15:0] verts = '0;
   logic rsp_valid;
   logic signed [15:0] rsp_unit_x, rsp_unit_y, rsp_unit_z;
   logic rsp_degenerate;
   int fail_count, pending;
   int idle_cycles = 0;
   int sent = 0;
   int degen_seen = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   triangle_unit_normal dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_p1_x(verts[0]), .req_p1_y(verts[1]), .req_p1_z(verts[2]),
      .req_p2_x(verts[3]), .req_p2_y(verts[4]), .req_p2_z(verts[5]),
      .req_p3_x(verts[6]), .req_p3_y(verts[7]), .req_p3_z(verts[8]),
      .rsp_valid(rsp_valid), .rsp_unit_x(rsp_unit_x), .rsp_unit_y(rsp_unit_y),
      .rsp_unit_z(rsp_unit_z), .rsp_degenerate(rsp_degenerate)
   );

   triangle_unit_normal_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .verts(verts),
      .rsp_valid(rsp_valid), .rsp_unit_x(rsp_unit_x), .rsp_unit_y(rsp_unit_y),
      .rsp_unit_z(rsp_unit_z), .rsp_degenerate(rsp_degenerate),
      .fail_count(fail_count), .pending(pending)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("triangle_unit_normal_tb: done, errors");
            $finish;
         end
      end
      if (!reset && rsp_valid && rsp_degenerate) degen_seen <= degen_seen + 1;
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_triangle(input logic [8:0][15:0] v);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      verts = v;
      start = 1'b1;
      do @(posedge clock); while (busy);
      sent++;
      @(negedge clock);
   endtask

   function automatic logic [8:0][15:0] pick(input logic [15:0] a, b, c, d, e, f,
                                             g, h, k);
      return {k, h, g, f, e, d, c, b, a};
   endfunction

   function automatic logic [15:0] coord_rand(input int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 64)) - 32);
         default: return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
      endcase
   endfunction

   initial begin
      logic [8:0][15:0] v;
      int kind, mode;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // all-zero and repeated vertices
      send_triangle('0);
      send_triangle(pick(16'h0100, 16'h0200, 16'h0300, 16'h0100, 16'h0200, 16'h0300,
                         16'h0500, 16'h0600, 16'h0700));
      // collinear
      send_triangle(pick(16'h0, 16'h0, 16'h0, 16'h0100, 16'h0100, 16'h0100,
                         16'h0200, 16'h0200, 16'h0200));
      // axis-aligned normals, both signs
      send_triangle(pick(16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0,
                         16'h0, 16'h0100, 16'h0));
      send_triangle(pick(16'h0, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0,
                         16'h0100, 16'h0, 16'h0));
      send_triangle(pick(16'h0, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0,
                         16'h0, 16'h0, 16'h0100));
      send_triangle(pick(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0100,
                         16'h0100, 16'h0, 16'h0));
      send_triangle(pick(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0100,
                         16'h0, 16'h0100, 16'h0));
      // extremes
      send_triangle(pick(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                         16'h8000, 16'h7fff, 16'h8000));
      send_triangle(pick(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
                         16'h7fff, 16'h7fff, 16'h8000));
      send_triangle(pick(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                         16'h8000, 16'h8000, 16'h7fff));
      send_triangle(pick(16'hffff, 16'hffff, 16'hffff, 16'h0001, 16'h0000, 16'h0000,
                         16'h0000, 16'h0001, 16'h0001));
      send_triangle(pick(16'h0, 16'h0, 16'h0, 16'h7fff, 16'h7fff, 16'h7fff,
                         16'h8000, 16'h8000, 16'h8000));

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 2) begin
            start = 1'b0;
            while (pending != 0) @(negedge clock);
         end
         kind = $urandom_range(0, 9);
         mode = $urandom_range(0, 2);
         for (int j = 0; j < 9; j++) v[j] = coord_rand(mode == 2 ? 2 : mode);
         if (kind == 0) begin
            v[5:3] = v[2:0];
         end else if (kind == 1) begin
            v[8:6] = v[5:3];
         end else if (kind == 2) begin
            // third vertex on the line through the first two, unless the 16-bit sum wraps
            for (int j = 0; j < 3; j++)
               v[6 + j] = v[3 + j] + (v[3 + j] - v[j]);
         end else if (kind == 3) begin
            // flat in one axis plane
            v[5] = v[2];
            v[8] = v[2];
         end
         send_triangle(v);
      end
      start = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 8) @(negedge clock);
      $display("sent %0d triangles: degenerate, axis-aligned, extreme and random cases",
               sent);
      $display("degenerate results seen: %0d", degen_seen);
      if (fail_count == 0) begin
         $display("triangle_unit_normal_tb: done, clean");
      end else begin
         $display("triangle_unit_normal_tb: done, errors");
      end
      $finish;
   end

endmodule
